### rtl/stgpc_pkg.sv
// shared types, constants and register codes for the stereo channel strip
package stgpc_pkg;

    // sample width of the input and result fields
    localparam int SAMPLE_BITS = 24;

    // configuration port widths
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    // register widths
    localparam int BAND_GAIN_BITS = 15;
    localparam int CHAN_GAIN_BITS = 16;
    localparam int THRESH_BITS    = 23;
    localparam int RATIO_BITS     = 16;

    // register reset values
    localparam logic [BAND_GAIN_BITS-1:0] LOW_BAND_GAIN_RST  = 15'd16384;
    localparam logic [BAND_GAIN_BITS-1:0] HIGH_BAND_GAIN_RST = 15'd16384;
    localparam logic [CHAN_GAIN_BITS-1:0] LEFT_GAIN_RST      = 16'd4096;
    localparam logic [CHAN_GAIN_BITS-1:0] RIGHT_GAIN_RST     = 16'd4096;
    localparam logic [THRESH_BITS-1:0]    COMP_THRESHOLD_RST = 23'd8388607;
    localparam logic [RATIO_BITS-1:0]     RATIO_RECIP_RST    = 16'd65535;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LOW_BAND_GAIN    = 3'd0,
        REG_HIGH_BAND_GAIN   = 3'd1,
        REG_LEFT_GAIN        = 3'd2,
        REG_RIGHT_GAIN       = 3'd3,
        REG_COMP_THRESHOLD   = 3'd4,
        REG_RATIO_RECIPROCAL = 3'd5,
        REG_COMP_ENABLE      = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } out_t;

    // registers shared by both lanes
    typedef struct packed {
        logic [BAND_GAIN_BITS-1:0] low_band_gain;
        logic [BAND_GAIN_BITS-1:0] high_band_gain;
        logic [THRESH_BITS-1:0]    comp_threshold;
        logic [RATIO_BITS-1:0]     ratio_reciprocal;
        logic                      comp_enable;
    } lane_cfg_t;

    // per-stage load strobes from the sequencer to the lanes
    typedef struct packed {
        logic lp;
        logic mul;
        logic band;
        logic chan;
        logic comp;
    } step_t;

endpackage

### rtl/stgpc_ctrl.sv
// sequencer that walks one stereo pair through the lane stages
module stgpc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 out_free,
    output logic                 s_ready,
    output logic                 load_out,
    output stgpc_pkg::step_t     step
);
    import stgpc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_BAND = 6'b000100,
        ST_CHAN = 6'b001000,
        ST_COMP = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign load_out = (state_reg == ST_DONE) && out_free;
    assign s_ready  = (state_reg == ST_IDLE) || load_out;
    assign accept   = s_valid && s_ready;

    assign step.lp   = accept;
    assign step.mul  = (state_reg == ST_MUL);
    assign step.band = (state_reg == ST_BAND);
    assign step.chan = (state_reg == ST_CHAN);
    assign step.comp = (state_reg == ST_COMP);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_BAND;
            ST_BAND: state_next = ST_CHAN;
            ST_CHAN: state_next = ST_COMP;
            ST_COMP: state_next = ST_DONE;
            ST_DONE: begin
                if (load_out) state_next = accept ? ST_MUL : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/stgpc_lane.sv
// one channel: lowpass split, tilt, level/pan gain, compressor, saturation
module stgpc_lane (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  stgpc_pkg::step_t                           step,
    input  stgpc_pkg::lane_cfg_t                       cfg,
    input  logic [stgpc_pkg::CHAN_GAIN_BITS-1:0]       gain,
    input  logic signed [stgpc_pkg::SAMPLE_BITS-1:0]   x_in,
    output logic signed [stgpc_pkg::SAMPLE_BITS-1:0]   y_out
);
    import stgpc_pkg::*;

    localparam int W  = SAMPLE_BITS;
    localparam int YW = W + 9;

    // 0.18 in q1.15; 0.82 is folded in as prev + 0.18*(x - prev)
    localparam logic [12:0] LP_IN_COEF = 13'd5898;

    localparam logic signed [W+14:0] LP_RND   = (W+15)'(1) <<< 14;
    localparam logic signed [W+17:0] BAND_RND = (W+18)'(1) <<< 13;
    localparam logic signed [W+20:0] CHAN_RND = (W+21)'(1) <<< 11;
    localparam logic [YW+15:0]       COMP_RND = (YW+16)'(1) << 15;

    localparam logic signed [YW+1:0] SAT_HI = (YW+2)'((64'sd1 <<< (W-1)) - 64'sd1);
    localparam logic signed [YW+1:0] SAT_LO = -SAT_HI - (YW+2)'(1);

    logic signed [W-1:0]    lp_reg, x_reg;
    logic signed [W+15:0]   pl_reg;
    logic signed [W+16:0]   ph_reg;
    logic signed [W+3:0]    band_reg;
    logic signed [YW-1:0]   y_reg;
    logic [YW+15:0]         prod_reg;
    logic                   neg_reg, over_reg;

    logic signed [W:0]      lp_diff;
    logic signed [W+14:0]   lp_prod, lp_rnd;
    logic signed [W-1:0]    lp_next;
    logic signed [W:0]      high;
    logic signed [W+17:0]   band_sum;
    logic signed [W+20:0]   y_prod, y_rnd;
    logic [YW-1:0]          mag, thr, excess;
    logic [YW+15:0]         prod_rnd;
    logic [YW:0]            cmag;
    logic signed [YW+1:0]   comp_val, val;

    // lowpass update
    assign lp_diff = {x_in[W-1], x_in} - {lp_reg[W-1], lp_reg};
    assign lp_prod = lp_diff * $signed({1'b0, LP_IN_COEF});
    assign lp_rnd  = lp_prod + LP_RND;
    assign lp_next = lp_reg + lp_rnd[W+14:15];

    // tilt
    assign high     = {x_reg[W-1], x_reg} - {lp_reg[W-1], lp_reg};
    assign band_sum = (W+18)'(pl_reg) + (W+18)'(ph_reg) + BAND_RND;

    // level and pan
    assign y_prod = band_reg * $signed({1'b0, gain});
    assign y_rnd  = y_prod + CHAN_RND;

    // compressor on the magnitude
    assign mag    = y_reg[YW-1] ? YW'(-y_reg) : YW'(y_reg);
    assign thr    = YW'(cfg.comp_threshold);
    assign excess = mag - thr;

    assign prod_rnd = prod_reg + COMP_RND;
    assign cmag     = {1'b0, thr} + {1'b0, prod_rnd[YW+15:16]};
    assign comp_val = neg_reg ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
    assign val      = over_reg ? comp_val : (YW+2)'(y_reg);

    always_comb begin
        if (val > SAT_HI) begin
            y_out = SAT_HI[W-1:0];
        end else if (val < SAT_LO) begin
            y_out = SAT_LO[W-1:0];
        end else begin
            y_out = val[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lp_reg <= '0;
        end else if (step.lp) begin
            lp_reg <= lp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step.lp) begin
            x_reg <= x_in;
        end
        if (step.mul) begin
            pl_reg <= lp_reg * $signed({1'b0, cfg.low_band_gain});
            ph_reg <= high * $signed({1'b0, cfg.high_band_gain});
        end
        if (step.band) begin
            band_reg <= band_sum[W+17:14];
        end
        if (step.chan) begin
            y_reg <= y_rnd[W+20:12];
        end
        if (step.comp) begin
            prod_reg <= excess * cfg.ratio_reciprocal;
            neg_reg  <= y_reg[YW-1];
            over_reg <= cfg.comp_enable && (mag > thr);
        end
    end

endmodule

### rtl/stereo_tilt_gain_pan_compressor.sv
// top level of the stereo tilt, gain, pan and compressor channel strip
//
// one stereo pair per input transaction, one processed pair per result
// transaction. two identical lanes (left and right) each run a one-pole
// lowpass split (0.82/0.18), tilt gains on the low and high bands, the
// per-channel level/pan gain, an optional hard-knee compressor on the
// magnitude and saturation to the sample width. a shared sequencer steps
// both lanes through five registered stages (lowpass, tilt products, band
// sum, channel gain, compressor product), with the multiplies spread over
// the stages, and the merge stage packs both lane results into the output
// register. a result moves there once it has passed all five lane stages
// and the output register is free, and the next pair is taken in the same
// cycle the previous result moves to the output register, so a new pair is
// taken only after the previous pair has left the lanes. a result waiting
// on m_ready holds the lanes in their last stage; the input side then
// stalls.
// configuration writes are always accepted (cfg_ready high) and must only
// be issued while no pair is in flight. registers: 0 low band gain q1.14,
// 1 high band gain q1.14, 2 left gain q4.12, 3 right gain q4.12,
// 4 compressor threshold, 5 ratio reciprocal q0.16, 6 compressor enable;
// writes to other indexes are ignored and excess data bits are dropped
module stereo_tilt_gain_pan_compressor (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input pair channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  stgpc_pkg::in_t                        s_data,
    // result pair channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output stgpc_pkg::out_t                       m_data,
    // register write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [stgpc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [stgpc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import stgpc_pkg::*;

    // configuration registers
    logic [BAND_GAIN_BITS-1:0] low_band_gain_reg, high_band_gain_reg;
    logic [CHAN_GAIN_BITS-1:0] left_gain_reg, right_gain_reg;
    logic [THRESH_BITS-1:0]    comp_threshold_reg;
    logic [RATIO_BITS-1:0]     ratio_reciprocal_reg;
    logic                      comp_enable_reg;

    // output register (merge stage)
    logic  m_valid_reg, m_valid_next;
    out_t  m_data_reg, m_data_next;

    lane_cfg_t lane_cfg;
    step_t     step;
    logic      load_out;
    logic      out_free;
    logic signed [SAMPLE_BITS-1:0] left_y, right_y;

    assign cfg_ready = 1'b1;

    // register writes, unknown indexes fall through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_band_gain_reg    <= LOW_BAND_GAIN_RST;
            high_band_gain_reg   <= HIGH_BAND_GAIN_RST;
            left_gain_reg        <= LEFT_GAIN_RST;
            right_gain_reg       <= RIGHT_GAIN_RST;
            comp_threshold_reg   <= COMP_THRESHOLD_RST;
            ratio_reciprocal_reg <= RATIO_RECIP_RST;
            comp_enable_reg      <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_index_t'(cfg_index))
                REG_LOW_BAND_GAIN:    low_band_gain_reg    <= cfg_data[BAND_GAIN_BITS-1:0];
                REG_HIGH_BAND_GAIN:   high_band_gain_reg   <= cfg_data[BAND_GAIN_BITS-1:0];
                REG_LEFT_GAIN:        left_gain_reg        <= cfg_data[CHAN_GAIN_BITS-1:0];
                REG_RIGHT_GAIN:       right_gain_reg       <= cfg_data[CHAN_GAIN_BITS-1:0];
                REG_COMP_THRESHOLD:   comp_threshold_reg   <= cfg_data[THRESH_BITS-1:0];
                REG_RATIO_RECIPROCAL: ratio_reciprocal_reg <= cfg_data[RATIO_BITS-1:0];
                REG_COMP_ENABLE:      comp_enable_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign lane_cfg.low_band_gain    = low_band_gain_reg;
    assign lane_cfg.high_band_gain   = high_band_gain_reg;
    assign lane_cfg.comp_threshold   = comp_threshold_reg;
    assign lane_cfg.ratio_reciprocal = ratio_reciprocal_reg;
    assign lane_cfg.comp_enable      = comp_enable_reg;

    // output register can take a result when empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    stgpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .out_free (out_free),
        .s_ready  (s_ready),
        .load_out (load_out),
        .step     (step)
    );

    // left lane
    stgpc_lane u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cfg     (lane_cfg),
        .gain    (left_gain_reg),
        .x_in    (s_data.left_in),
        .y_out   (left_y)
    );

    // right lane
    stgpc_lane u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cfg     (lane_cfg),
        .gain    (right_gain_reg),
        .x_in    (s_data.right_in),
        .y_out   (right_y)
    );

    // merge both lanes into one result transaction
    always_comb begin
        m_data_next = m_data_reg;
        if (load_out) begin
            m_data_next.left_out  = left_y;
            m_data_next.right_out = right_y;
        end
    end

    assign m_valid_next = load_out || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/stgpc_checker.sv
// port-level checks for the channel strip, bound to the top level
module stgpc_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  stgpc_pkg::out_t                       m_data
);
    import stgpc_pkg::*;

    // a pending result stays offered
    a_m_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before it was taken");

    // a pending result keeps its payload
    a_m_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result payload changed while stalled");

    // one pair at a time: no input right after an accepted transaction
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a pair is in flight");

    // a fresh result follows its input by the lane depth
    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 6))
        else $error("result appeared without a matching input transaction");

endmodule

bind stereo_tilt_gain_pan_compressor stgpc_checker u_checker (.*);
